// ===== src/adsr_envelope_generator_macros.svh =====
// ----------------------------------------------------------------------------
// ADSR envelope generator assertion macros
// Concurrent assertion wrappers shared by the envelope generator RTL.
// ----------------------------------------------------------------------------
`ifndef ADSR_ENVELOPE_GENERATOR_MACROS_SVH
`define ADSR_ENVELOPE_GENERATOR_MACROS_SVH

`ifndef ASSERT_OFF

// Checks that the consequent holds in the same cycle as the antecedent.
`define ADSR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("envelope generator check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define ADSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("envelope generator check failed");

`else

`define ADSR_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ADSR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/adsr_pkg.sv =====
// ----------------------------------------------------------------------------
// ADSR envelope generator package
// Widths, payload types, phase and register codes shared by the design.
// ----------------------------------------------------------------------------
package adsr_pkg;

    localparam int LEVEL_BITS     = 16;
    localparam int COUNT_BITS     = 32;
    localparam int LEN_BITS       = 16;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = (LEVEL_BITS > LEN_BITS) ? LEVEL_BITS : LEN_BITS;
    localparam int ITER_BITS      = $clog2(LEVEL_BITS);

    typedef logic [LEVEL_BITS-1:0]     level_t;
    typedef logic [COUNT_BITS-1:0]     count_t;
    typedef logic [LEN_BITS-1:0]       len_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;
    typedef logic [ITER_BITS-1:0]      iter_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_LOAD,
        CS_DIV,
        CS_FINISH
    } ctrl_state_t;

    localparam cfg_index_t CFG_ATTACK_TARGET  = cfg_index_t'(0);
    localparam cfg_index_t CFG_ATTACK_LENGTH  = cfg_index_t'(1);
    localparam cfg_index_t CFG_DECAY_TARGET   = cfg_index_t'(2);
    localparam cfg_index_t CFG_DECAY_LENGTH   = cfg_index_t'(3);
    localparam cfg_index_t CFG_SUSTAIN_TARGET = cfg_index_t'(4);
    localparam cfg_index_t CFG_SUSTAIN_LENGTH = cfg_index_t'(5);
    localparam cfg_index_t CFG_RELEASE_TARGET = cfg_index_t'(6);
    localparam cfg_index_t CFG_RELEASE_LENGTH = cfg_index_t'(7);

endpackage

// ===== src/adsr_cfg_if.sv =====
// ----------------------------------------------------------------------------
// ADSR configuration write channel
// Carries a register index and write data under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface adsr_cfg_if;
    import adsr_pkg::*;

    logic       valid;
    logic       ready;
    cfg_index_t index;
    cfg_data_t  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/adsr_tick_if.sv =====
// ----------------------------------------------------------------------------
// ADSR tick channel
// Carries the gate and the time count of one envelope tick.
// ----------------------------------------------------------------------------
interface adsr_tick_if;
    import adsr_pkg::*;

    logic   valid;
    logic   ready;
    logic   gate_on;
    count_t now_count;

    modport source (output valid, gate_on, now_count, input ready);
    modport sink (input valid, gate_on, now_count, output ready);
endinterface

// ===== src/adsr_result_if.sv =====
// ----------------------------------------------------------------------------
// ADSR result channel
// Carries the envelope level, phase and gate clear flag of one tick.
// ----------------------------------------------------------------------------
interface adsr_result_if;
    import adsr_pkg::*;

    logic       valid;
    logic       ready;
    level_t     level;
    logic [2:0] phase;
    logic       gate_clear;

    modport source (output valid, level, phase, gate_clear, input ready);
    modport sink (input valid, level, phase, gate_clear, output ready);
endinterface

// ===== src/adsr_envelope_generator.sv =====
// ----------------------------------------------------------------------------
// ADSR envelope generator
// Linear five-phase envelope with a bit-serial ramp multiply-divide unit.
// ----------------------------------------------------------------------------
//  channel | role   | payload                   | transfer
//  cfg     | sink   | index, data               | valid && ready, always ready
//  tick    | sink   | gate_on, now_count        | valid && ready
//  result  | source | level, phase, gate_clear  | valid && ready
//
//  After a tick transfer the sequencer runs a load state, LEVEL_BITS divider
//  iterations and a commit state before it can take the next tick.
//  The divider retires one quotient bit per cycle.
//  A finished result waits in the output register; a stalled result channel
//  holds the commit cycle until the register frees up.
//  Reset clears all configuration and envelope state to zero and idle.
// ----------------------------------------------------------------------------
`include "adsr_envelope_generator_macros.svh"

module adsr_envelope_generator (
    input logic           clk,
    input logic           rst_n,
    adsr_cfg_if.sink      cfg,
    adsr_tick_if.sink     tick,
    adsr_result_if.source result
);
    import adsr_pkg::*;

    ctrl_state_t ctrl_state_reg, ctrl_state_next;

    level_t attack_target_reg, decay_target_reg, sustain_target_reg, release_target_reg;
    len_t   attack_length_reg, decay_length_reg, sustain_length_reg, release_length_reg;

    phase_t phase_reg, phase_next;
    count_t phase_start_reg, phase_start_next;
    level_t attack_origin_reg, attack_origin_next;
    level_t attack_level_reg, attack_level_next;
    level_t decay_level_reg, decay_level_next;
    level_t sustain_level_reg, sustain_level_next;
    level_t release_level_reg, release_level_next;
    level_t held_level_reg;
    level_t level_new;
    logic   clear_new;

    logic   gate_reg;
    count_t now_reg;

    level_t div_num_reg, div_num_next;
    len_t   div_mul_reg, div_mul_next;
    len_t   div_den_reg;
    len_t   div_rem_reg, div_rem_next;
    level_t div_quo_reg, div_quo_next;
    iter_t  div_cnt_reg;

    logic               out_valid_reg;
    level_t             out_level_reg;
    phase_t             out_phase_reg;
    logic               out_clear_reg;

    logic               out_free;
    logic               commit;
    logic               tick_xfer;

    count_t elapsed;
    level_t from_sel, to_sel;
    len_t   len_sel;
    logic   past_len;
    logic   ramp_up;
    level_t ramp_val;

    logic [LEN_BITS:0] den_ext, rem_shift, rem_a, rem_b, rem_c;
    logic              step1_ge, step2_ge;

    assign cfg.ready  = 1'b1;
    assign tick.ready = (ctrl_state_reg == CS_IDLE);
    assign tick_xfer  = tick.valid && tick.ready;
    assign out_free   = !out_valid_reg || result.ready;

    assign result.valid      = out_valid_reg;
    assign result.level      = out_level_reg;
    assign result.phase      = out_phase_reg;
    assign result.gate_clear = out_clear_reg;

    // Ramp operands of the present phase.
    always_comb
    begin
        unique case (phase_reg)
            PH_ATTACK:
            begin
                from_sel = attack_origin_reg;
                to_sel   = attack_target_reg;
                len_sel  = attack_length_reg;
            end
            PH_DECAY:
            begin
                from_sel = attack_level_reg;
                to_sel   = decay_target_reg;
                len_sel  = decay_length_reg;
            end
            PH_SUSTAIN:
            begin
                from_sel = decay_level_reg;
                to_sel   = sustain_target_reg;
                len_sel  = sustain_length_reg;
            end
            default:
            begin
                from_sel = sustain_level_reg;
                to_sel   = release_target_reg;
                len_sel  = release_length_reg;
            end
        endcase
    end

    assign elapsed  = now_reg - phase_start_reg;
    assign past_len = elapsed > COUNT_BITS'(len_sel);
    assign ramp_up  = to_sel >= from_sel;

    always_comb
    begin
        if (len_sel == '0)
        begin
            ramp_val = to_sel;
        end
        else if (ramp_up)
        begin
            ramp_val = from_sel + div_quo_reg;
        end
        else
        begin
            ramp_val = from_sel - div_quo_reg;
        end
    end

    assign div_num_next = ramp_up ? (to_sel - from_sel) : (from_sel - to_sel);
    assign div_mul_next = past_len ? len_sel : elapsed[LEN_BITS-1:0];

    // One iteration of the shift-and-subtract multiply-divide per cycle.
    always_comb
    begin
        den_ext   = {1'b0, div_den_reg};
        rem_shift = {div_rem_reg, 1'b0};
        step1_ge  = rem_shift >= den_ext;
        rem_a     = step1_ge ? (rem_shift - den_ext) : rem_shift;
        rem_b     = div_num_reg[LEVEL_BITS-1] ? (rem_a + {1'b0, div_mul_reg}) : rem_a;
        step2_ge  = div_num_reg[LEVEL_BITS-1] && (rem_b >= den_ext);
        rem_c     = step2_ge ? (rem_b - den_ext) : rem_b;
        div_rem_next = rem_c[LEN_BITS-1:0];
        div_quo_next = {div_quo_reg[LEVEL_BITS-2:0], 1'b0} + LEVEL_BITS'(step1_ge)
                       + LEVEL_BITS'(step2_ge);
    end

    // Envelope phase update for the tick being committed.
    always_comb
    begin
        phase_next         = phase_reg;
        phase_start_next   = phase_start_reg;
        attack_origin_next = attack_origin_reg;
        attack_level_next  = attack_level_reg;
        decay_level_next   = decay_level_reg;
        sustain_level_next = sustain_level_reg;
        release_level_next = release_level_reg;
        level_new          = held_level_reg;
        clear_new          = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (gate_reg)
                begin
                    phase_next         = PH_ATTACK;
                    phase_start_next   = now_reg;
                    attack_origin_next = '0;
                    level_new          = '0;
                end
            end
            PH_ATTACK:
            begin
                if (past_len)
                begin
                    phase_next        = PH_DECAY;
                    phase_start_next  = now_reg;
                    attack_level_next = attack_target_reg;
                end
                else if (!gate_reg)
                begin
                    phase_next         = PH_RELEASE;
                    phase_start_next   = now_reg;
                    decay_level_next   = attack_level_reg;
                    sustain_level_next = attack_level_reg;
                    release_level_next = attack_level_reg;
                end
                else
                begin
                    attack_level_next = ramp_val;
                end
                level_new = attack_level_next;
            end
            PH_DECAY:
            begin
                if (past_len)
                begin
                    phase_next       = PH_SUSTAIN;
                    phase_start_next = now_reg;
                    decay_level_next = decay_target_reg;
                end
                else if (!gate_reg)
                begin
                    phase_next         = PH_RELEASE;
                    phase_start_next   = now_reg;
                    sustain_level_next = decay_level_reg;
                    release_level_next = decay_level_reg;
                end
                else
                begin
                    decay_level_next = ramp_val;
                end
                level_new = decay_level_next;
            end
            PH_SUSTAIN:
            begin
                sustain_level_next = past_len ? sustain_target_reg : ramp_val;
                if (!gate_reg)
                begin
                    phase_next         = PH_RELEASE;
                    phase_start_next   = now_reg;
                    release_level_next = sustain_level_next;
                end
                level_new = sustain_level_next;
            end
            default:
            begin
                if (past_len)
                begin
                    phase_next         = PH_IDLE;
                    attack_origin_next = '0;
                    clear_new          = 1'b1;
                    level_new          = '0;
                end
                else if (gate_reg)
                begin
                    phase_next         = PH_ATTACK;
                    phase_start_next   = now_reg;
                    attack_origin_next = release_level_reg;
                    level_new          = release_level_reg;
                end
                else
                begin
                    release_level_next = ramp_val;
                    level_new          = ramp_val;
                end
            end
        endcase
    end

    // Tick sequencer.
    always_comb
    begin
        ctrl_state_next = ctrl_state_reg;
        commit          = 1'b0;
        unique case (ctrl_state_reg)
            CS_IDLE:
            begin
                if (tick_xfer)
                begin
                    ctrl_state_next = CS_LOAD;
                end
            end
            CS_LOAD:
            begin
                ctrl_state_next = CS_DIV;
            end
            CS_DIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    ctrl_state_next = CS_FINISH;
                end
            end
            CS_FINISH:
            begin
                if (out_free)
                begin
                    commit          = 1'b1;
                    ctrl_state_next = CS_IDLE;
                end
            end
            default:
            begin
                ctrl_state_next = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_state_reg <= CS_IDLE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            ctrl_state_reg <= ctrl_state_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_target_reg  <= '0;
            attack_length_reg  <= '0;
            decay_target_reg   <= '0;
            decay_length_reg   <= '0;
            sustain_target_reg <= '0;
            sustain_length_reg <= '0;
            release_target_reg <= '0;
            release_length_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_ATTACK_TARGET:  attack_target_reg  <= cfg.data[LEVEL_BITS-1:0];
                CFG_ATTACK_LENGTH:  attack_length_reg  <= cfg.data[LEN_BITS-1:0];
                CFG_DECAY_TARGET:   decay_target_reg   <= cfg.data[LEVEL_BITS-1:0];
                CFG_DECAY_LENGTH:   decay_length_reg   <= cfg.data[LEN_BITS-1:0];
                CFG_SUSTAIN_TARGET: sustain_target_reg <= cfg.data[LEVEL_BITS-1:0];
                CFG_SUSTAIN_LENGTH: sustain_length_reg <= cfg.data[LEN_BITS-1:0];
                CFG_RELEASE_TARGET: release_target_reg <= cfg.data[LEVEL_BITS-1:0];
                CFG_RELEASE_LENGTH: release_length_reg <= cfg.data[LEN_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            phase_start_reg   <= '0;
            attack_origin_reg <= '0;
            attack_level_reg  <= '0;
            decay_level_reg   <= '0;
            sustain_level_reg <= '0;
            release_level_reg <= '0;
            held_level_reg    <= '0;
        end
        else if (commit)
        begin
            phase_reg         <= phase_next;
            phase_start_reg   <= phase_start_next;
            attack_origin_reg <= attack_origin_next;
            attack_level_reg  <= attack_level_next;
            decay_level_reg   <= decay_level_next;
            sustain_level_reg <= sustain_level_next;
            release_level_reg <= release_level_next;
            held_level_reg    <= level_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_xfer)
        begin
            gate_reg <= tick.gate_on;
            now_reg  <= tick.now_count;
        end
        if (ctrl_state_reg == CS_LOAD)
        begin
            div_num_reg <= div_num_next;
            div_mul_reg <= div_mul_next;
            div_den_reg <= len_sel;
            div_rem_reg <= '0;
            div_quo_reg <= '0;
            div_cnt_reg <= iter_t'(LEVEL_BITS - 1);
        end
        else if (ctrl_state_reg == CS_DIV)
        begin
            div_num_reg <= {div_num_reg[LEVEL_BITS-2:0], 1'b0};
            div_rem_reg <= div_rem_next;
            div_quo_reg <= div_quo_next;
            div_cnt_reg <= div_cnt_reg - iter_t'(1);
        end
        if (commit)
        begin
            out_level_reg <= level_new;
            out_phase_reg <= phase_next;
            out_clear_reg <= clear_new;
        end
    end

    `ADSR_ASSERT_SAME(a_clear_means_idle_zero, clk, rst_n, result.valid && result.gate_clear, (result.phase == PH_IDLE) && (result.level == '0))
    `ADSR_ASSERT_SAME(a_rem_below_divisor, clk, rst_n, (ctrl_state_reg == CS_DIV) && (div_den_reg != '0), div_rem_reg < div_den_reg)
    `ADSR_ASSERT_NEXT(a_finish_presents_result, clk, rst_n, (ctrl_state_reg == CS_FINISH) && out_free, result.valid && (ctrl_state_reg == CS_IDLE))

endmodule

// ===== verif/adsr_envelope_generator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ADSR envelope generator testbench
// Drives envelope ticks and register writes through the valid/ready channels.
// A directed table covers zero lengths, extreme levels, early release, regate
// and count wrap. Random phases with varied register settings follow. Every
// result transfer is checked field by field against its typed row or a predicted envelope.
// ----------------------------------------------------------------------------
module adsr_envelope_generator_tb;
    import adsr_pkg::*;

    localparam cfg_index_t CFG_FIRST_UNUSED = cfg_index_t'(8);
    localparam cfg_index_t CFG_LAST_UNUSED  = cfg_index_t'(15);
    localparam int         RANDOM_PHASES    = 11;
    localparam int         TICKS_PER_PHASE  = 100;

    typedef struct packed {
        level_t     level;
        logic [2:0] phase;
        logic       gate_clear;
    } env_result_t;

    typedef struct {
        bit          typed;
        env_result_t want;
    } typed_result_t;

    typedef struct {
        bit          is_cfg;
        cfg_index_t  index;
        cfg_data_t   data;
        logic        gate_bit;
        count_t      count;
        bit          typed;
        env_result_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    adsr_cfg_if    cfg_if();
    adsr_tick_if   tick_if();
    adsr_result_if result_if();

    adsr_envelope_generator u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_if),
        .tick   (tick_if),
        .result (result_if)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    level_t reg_attack_target  = '0;
    len_t   reg_attack_length  = '0;
    level_t reg_decay_target   = '0;
    len_t   reg_decay_length   = '0;
    level_t reg_sustain_target = '0;
    len_t   reg_sustain_length = '0;
    level_t reg_release_target = '0;
    len_t   reg_release_length = '0;

    phase_t env_phase         = PH_IDLE;
    count_t env_start         = '0;
    level_t env_attack_origin = '0;
    level_t env_attack_level  = '0;
    level_t env_decay_level   = '0;
    level_t env_sustain_level = '0;
    level_t env_release_level = '0;
    level_t env_held          = '0;

    env_result_t   expected_envelopes[$];
    typed_result_t typed_results[$];
    stim_row_t     directed_rows[$];

    int unsigned ticks_sent = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned burst_left = 0;
    bit          cfg_held = 1'b0;

    logic [15:0] stall_pattern = '1;
    logic [7:0]  stall_slot = '0;

    function automatic level_t ramp_point(level_t from, level_t to, count_t elapsed, len_t len);
        logic [31:0] span;
        logic [31:0] t;
        if (len == '0)
        begin
            return to;
        end
        t = (elapsed > count_t'(len)) ? 32'(len) : 32'(elapsed);
        if (to >= from)
        begin
            span = 32'(to) - 32'(from);
            return level_t'(32'(from) + (span * t) / 32'(len));
        end
        span = 32'(from) - 32'(to);
        return level_t'(32'(from) - (span * t) / 32'(len));
    endfunction

    function automatic void envelope_config(cfg_index_t index, cfg_data_t data);
        case (index)
            CFG_ATTACK_TARGET:  reg_attack_target  = level_t'(data);
            CFG_ATTACK_LENGTH:  reg_attack_length  = len_t'(data);
            CFG_DECAY_TARGET:   reg_decay_target   = level_t'(data);
            CFG_DECAY_LENGTH:   reg_decay_length   = len_t'(data);
            CFG_SUSTAIN_TARGET: reg_sustain_target = level_t'(data);
            CFG_SUSTAIN_LENGTH: reg_sustain_length = len_t'(data);
            CFG_RELEASE_TARGET: reg_release_target = level_t'(data);
            CFG_RELEASE_LENGTH: reg_release_length = len_t'(data);
            default:            ;
        endcase
    endfunction

    function automatic env_result_t envelope_step(logic gate_bit, count_t count);
        count_t      elapsed;
        level_t      lvl;
        logic        clr;
        env_result_t res;
        elapsed = count - env_start;
        lvl = env_held;
        clr = 1'b0;
        case (env_phase)
            PH_IDLE:
            begin
                if (gate_bit)
                begin
                    env_phase = PH_ATTACK;
                    env_start = count;
                    env_attack_origin = '0;
                    lvl = '0;
                end
            end
            PH_ATTACK:
            begin
                if (elapsed > count_t'(reg_attack_length))
                begin
                    env_phase = PH_DECAY;
                    env_start = count;
                    env_attack_level = reg_attack_target;
                end
                else if (!gate_bit)
                begin
                    env_phase = PH_RELEASE;
                    env_start = count;
                    env_decay_level = env_attack_level;
                    env_sustain_level = env_attack_level;
                    env_release_level = env_attack_level;
                end
                else
                begin
                    env_attack_level = ramp_point(env_attack_origin, reg_attack_target,
                                                  elapsed, reg_attack_length);
                end
                lvl = env_attack_level;
            end
            PH_DECAY:
            begin
                if (elapsed > count_t'(reg_decay_length))
                begin
                    env_phase = PH_SUSTAIN;
                    env_start = count;
                    env_decay_level = reg_decay_target;
                end
                else if (!gate_bit)
                begin
                    env_phase = PH_RELEASE;
                    env_start = count;
                    env_sustain_level = env_decay_level;
                    env_release_level = env_decay_level;
                end
                else
                begin
                    env_decay_level = ramp_point(env_attack_level, reg_decay_target,
                                                 elapsed, reg_decay_length);
                end
                lvl = env_decay_level;
            end
            PH_SUSTAIN:
            begin
                if (elapsed > count_t'(reg_sustain_length))
                begin
                    env_sustain_level = reg_sustain_target;
                end
                else
                begin
                    env_sustain_level = ramp_point(env_decay_level, reg_sustain_target,
                                                   elapsed, reg_sustain_length);
                end
                if (!gate_bit)
                begin
                    env_phase = PH_RELEASE;
                    env_start = count;
                    env_release_level = env_sustain_level;
                end
                lvl = env_sustain_level;
            end
            default:
            begin
                if (elapsed > count_t'(reg_release_length))
                begin
                    env_phase = PH_IDLE;
                    env_attack_origin = '0;
                    clr = 1'b1;
                    lvl = '0;
                end
                else if (gate_bit)
                begin
                    env_phase = PH_ATTACK;
                    env_start = count;
                    env_attack_origin = env_release_level;
                    lvl = env_release_level;
                end
                else
                begin
                    env_release_level = ramp_point(env_sustain_level, reg_release_target,
                                                   elapsed, reg_release_length);
                    lvl = env_release_level;
                end
            end
        endcase
        env_held = lvl;
        res.level = lvl;
        res.phase = env_phase;
        res.gate_clear = clr;
        return res;
    endfunction

    function automatic stim_row_t tick_row(logic gate_bit, count_t count, bit typed,
                                           level_t lvl, phase_t ph, logic clr);
        stim_row_t row;
        row.is_cfg = 1'b0;
        row.index = '0;
        row.data = '0;
        row.gate_bit = gate_bit;
        row.count = count;
        row.typed = typed;
        row.want.level = lvl;
        row.want.phase = ph;
        row.want.gate_clear = clr;
        return row;
    endfunction

    function automatic stim_row_t reg_row(cfg_index_t index, cfg_data_t data);
        stim_row_t row;
        row = tick_row(1'b0, '0, 1'b0, '0, PH_IDLE, 1'b0);
        row.is_cfg = 1'b1;
        row.index = index;
        row.data = data;
        return row;
    endfunction

    function automatic level_t pick_level(int p);
        if (p % 3 == 0)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                return '1;
            end
            return '0;
        end
        return level_t'($urandom);
    endfunction

    function automatic len_t pick_length(int p);
        case (p % 4)
            0:       return len_t'($urandom_range(0, 8));
            1:       return len_t'($urandom_range(0, 300));
            2:       return ($urandom_range(0, 1) == 1) ? len_t'(16'hFFFF) : len_t'(16'h0000);
            default: return len_t'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string what, int unsigned idx, logic [31:0] got,
                                   logic [31:0] want);
        $display("ERROR: result %0d %s: got %0h, wanted %0h", idx, what, got, want);
        mismatches++;
    endtask

    task automatic drain_results();
        tick_if.valid <= 1'b0;
        while (results_seen != ticks_sent)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input cfg_index_t index, input cfg_data_t data);
        drain_results();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= index;
        cfg_if.data <= data;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_held = 1'b1;
    endtask

    task automatic send_tick(input logic gate_bit, input count_t count, input bit typed,
                             input env_result_t want);
        int unsigned   gap;
        typed_result_t note;
        if (cfg_held)
        begin
            cfg_if.valid <= 1'b0;
            cfg_held = 1'b0;
        end
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            burst_left = $urandom_range(1, 16);
            if (gap != 0)
            begin
                tick_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        note.typed = typed;
        note.want = want;
        typed_results.push_back(note);
        tick_if.valid <= 1'b1;
        tick_if.gate_on <= gate_bit;
        tick_if.now_count <= count;
        do @(posedge clk); while (!tick_if.ready);
        ticks_sent++;
    endtask

    always @(posedge clk)
    begin : observe
        typed_result_t note;
        env_result_t   want;
        env_result_t   predicted;
        if (rst_n)
        begin
            if (cfg_if.valid && cfg_if.ready)
            begin
                envelope_config(cfg_if.index, cfg_if.data);
            end
            if (tick_if.valid && tick_if.ready)
            begin
                note = typed_results.pop_front();
                predicted = envelope_step(tick_if.gate_on, tick_if.now_count);
                expected_envelopes.push_back(note.typed ? note.want : predicted);
            end
            if (result_if.valid && result_if.ready)
            begin
                if (expected_envelopes.size() == 0)
                begin
                    report_mismatch("unexpected transfer", results_seen,
                                    32'(result_if.level), '0);
                end
                else
                begin
                    want = expected_envelopes.pop_front();
                    if (result_if.level !== want.level)
                    begin
                        report_mismatch("level", results_seen, 32'(result_if.level),
                                        32'(want.level));
                    end
                    if (result_if.phase !== want.phase)
                    begin
                        report_mismatch("phase", results_seen, 32'(result_if.phase),
                                        32'(want.phase));
                    end
                    if (result_if.gate_clear !== want.gate_clear)
                    begin
                        report_mismatch("gate_clear", results_seen,
                                        32'(result_if.gate_clear), 32'(want.gate_clear));
                    end
                end
                results_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
        end
        else
        begin
            if (stall_slot == '0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_pattern = '1;
                    1:       stall_pattern = 16'($urandom);
                    2:       stall_pattern = 16'($urandom) & 16'($urandom);
                    default: stall_pattern = 16'($urandom) | 16'($urandom);
                endcase
            end
            result_if.ready <= stall_pattern[stall_slot[3:0]];
            stall_slot = stall_slot + 8'd1;
        end
    end

    initial
    begin : stimulus
        level_t      a_t;
        len_t        a_l;
        level_t      d_t;
        len_t        d_l;
        level_t      s_t;
        len_t        s_l;
        level_t      r_t;
        len_t        r_l;
        int unsigned longest;
        int unsigned step_max;
        int unsigned gate_run;
        int unsigned roll;
        logic        gate_level;
        logic        item_gate;
        count_t      tick_count;
        env_result_t unused;

        tick_if.valid <= 1'b0;
        tick_if.gate_on <= 1'b0;
        tick_if.now_count <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= '0;
        cfg_if.data <= '0;
        unused = '0;

        // Reset registers are all zero, so every length is zero.
        directed_rows.push_back(tick_row(1'b0, 32'd0, 1'b1, 16'h0000, PH_IDLE, 1'b0));
        directed_rows.push_back(tick_row(1'b1, 32'd100, 1'b1, 16'h0000, PH_ATTACK, 1'b0));
        directed_rows.push_back(tick_row(1'b1, 32'd100, 1'b1, 16'h0000, PH_ATTACK, 1'b0));
        directed_rows.push_back(tick_row(1'b1, 32'd101, 1'b1, 16'h0000, PH_DECAY, 1'b0));
        directed_rows.push_back(tick_row(1'b1, 32'd102, 1'b1, 16'h0000, PH_SUSTAIN, 1'b0));
        directed_rows.push_back(tick_row(1'b1, 32'd103, 1'b1, 16'h0000, PH_SUSTAIN, 1'b0));
        directed_rows.push_back(tick_row(1'b0, 32'd103, 1'b1, 16'h0000, PH_RELEASE, 1'b0));
        directed_rows.push_back(tick_row(1'b0, 32'd104, 1'b1, 16'h0000, PH_IDLE, 1'b1));
        directed_rows.push_back(reg_row(CFG_ATTACK_TARGET, 16'hFFFF));
        directed_rows.push_back(reg_row(CFG_ATTACK_LENGTH, 16'h0000));
        directed_rows.push_back(reg_row(CFG_DECAY_TARGET, 16'h0000));
        directed_rows.push_back(reg_row(CFG_DECAY_LENGTH, 16'h0000));
        directed_rows.push_back(reg_row(CFG_SUSTAIN_TARGET, 16'hFFFF));
        directed_rows.push_back(reg_row(CFG_SUSTAIN_LENGTH, 16'h0000));
        directed_rows.push_back(reg_row(CFG_RELEASE_TARGET, 16'h0000));
        directed_rows.push_back(reg_row(CFG_RELEASE_LENGTH, 16'h0000));
        directed_rows.push_back(tick_row(1'b1, 32'd200, 1'b1, 16'h0000, PH_ATTACK, 1'b0));
        directed_rows.push_back(tick_row(1'b1, 32'd200, 1'b1, 16'hFFFF, PH_ATTACK, 1'b0));
        directed_rows.push_back(tick_row(1'b1, 32'd201, 1'b1, 16'hFFFF, PH_DECAY, 1'b0));
        directed_rows.push_back(tick_row(1'b1, 32'd201, 1'b1, 16'h0000, PH_DECAY, 1'b0));
        directed_rows.push_back(tick_row(1'b0, 32'd201, 1'b1, 16'h0000, PH_RELEASE, 1'b0));
        directed_rows.push_back(tick_row(1'b1, 32'd201, 1'b1, 16'h0000, PH_ATTACK, 1'b0));
        directed_rows.push_back(tick_row(1'b0, 32'd201, 1'b0, '0, PH_IDLE, 1'b0));
        directed_rows.push_back(tick_row(1'b0, 32'd202, 1'b1, 16'h0000, PH_IDLE, 1'b1));
        directed_rows.push_back(reg_row(CFG_ATTACK_LENGTH, 16'hFFFF));
        directed_rows.push_back(reg_row(CFG_DECAY_LENGTH, 16'hFFFF));
        directed_rows.push_back(reg_row(CFG_SUSTAIN_LENGTH, 16'h1000));
        directed_rows.push_back(reg_row(CFG_RELEASE_LENGTH, 16'hFFFF));
        directed_rows.push_back(reg_row(CFG_FIRST_UNUSED, 16'h1234));
        directed_rows.push_back(reg_row(CFG_LAST_UNUSED, 16'hFFFF));
        directed_rows.push_back(tick_row(1'b1, 32'hFFFF_FFF0, 1'b1, 16'h0000, PH_ATTACK, 1'b0));
        directed_rows.push_back(tick_row(1'b1, 32'h0000_7FF0, 1'b0, '0, PH_IDLE, 1'b0));
        directed_rows.push_back(tick_row(1'b1, 32'h0000_FFEF, 1'b0, '0, PH_IDLE, 1'b0));
        directed_rows.push_back(tick_row(1'b1, 32'h0001_FFF0, 1'b1, 16'hFFFF, PH_DECAY, 1'b0));
        directed_rows.push_back(tick_row(1'b0, 32'h0002_3FF0, 1'b0, '0, PH_IDLE, 1'b0));
        directed_rows.push_back(tick_row(1'b1, 32'h0002_4000, 1'b0, '0, PH_IDLE, 1'b0));
        directed_rows.push_back(tick_row(1'b1, 32'h0000_0005, 1'b0, '0, PH_IDLE, 1'b0));
        directed_rows.push_back(tick_row(1'b0, 32'hFFFF_FFFF, 1'b0, '0, PH_IDLE, 1'b0));
        directed_rows.push_back(tick_row(1'b0, 32'hFFFF_FFFF, 1'b0, '0, PH_IDLE, 1'b0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
            begin
                write_reg(directed_rows[i].index, directed_rows[i].data);
            end
            else
            begin
                send_tick(directed_rows[i].gate_bit, directed_rows[i].count,
                          directed_rows[i].typed, directed_rows[i].want);
            end
        end

        tick_count = count_t'($urandom);
        gate_level = 1'b0;
        gate_run = 0;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            a_t = pick_level(p);
            a_l = pick_length(p);
            d_t = pick_level(p);
            d_l = pick_length(p);
            s_t = pick_level(p);
            s_l = pick_length(p);
            r_t = pick_level(p);
            r_l = pick_length(p);
            write_reg(CFG_ATTACK_TARGET, cfg_data_t'(a_t));
            write_reg(CFG_ATTACK_LENGTH, cfg_data_t'(a_l));
            write_reg(CFG_DECAY_TARGET, cfg_data_t'(d_t));
            write_reg(CFG_DECAY_LENGTH, cfg_data_t'(d_l));
            write_reg(CFG_SUSTAIN_TARGET, cfg_data_t'(s_t));
            write_reg(CFG_SUSTAIN_LENGTH, cfg_data_t'(s_l));
            write_reg(CFG_RELEASE_TARGET, cfg_data_t'(r_t));
            write_reg(CFG_RELEASE_LENGTH, cfg_data_t'(r_l));
            if (p % 2 == 1)
            begin
                write_reg(cfg_index_t'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)),
                          cfg_data_t'($urandom));
            end
            longest = 32'(a_l);
            if (32'(d_l) > longest) longest = 32'(d_l);
            if (32'(s_l) > longest) longest = 32'(s_l);
            if (32'(r_l) > longest) longest = 32'(r_l);
            step_max = longest / 5 + 3;

            // Gate runs give full note shapes; a few ticks jump the count or glitch the gate.
            repeat (TICKS_PER_PHASE)
            begin
                if (gate_run == 0)
                begin
                    gate_level = !gate_level;
                    gate_run = gate_level ? $urandom_range(1, 40) : $urandom_range(1, 25);
                end
                gate_run--;
                item_gate = gate_level;
                roll = $urandom_range(0, 99);
                if (roll < 4)
                begin
                    tick_count = count_t'($urandom);
                end
                else
                begin
                    if (roll < 8)
                    begin
                        item_gate = !gate_level;
                    end
                    if (roll >= 12)
                    begin
                        tick_count = tick_count + count_t'($urandom_range(1, step_max));
                    end
                end
                send_tick(item_gate, tick_count, 1'b0, unused);
            end
        end

        drain_results();
        repeat (40) @(posedge clk);
        if (expected_envelopes.size() != 0)
        begin
            report_mismatch("missing transfers", results_seen, '0,
                            32'(expected_envelopes.size()));
        end
        if (mismatches == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial
    begin
        #(40_000_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
